FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define MTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/mte_pkg.sv
// Types, symbol codes and keypad tables for the multitap text encoder.
// No dependencies.
package mte_pkg;

  localparam int SymW  = 6;
  localparam int SlotN = 5;  // symbols of a run ahead of the closing star

  localparam logic [SymW-1:0] SYM_STAR  = 6'd42;
  localparam logic [SymW-1:0] SYM_MINUS = 6'd45;
  localparam logic [SymW-1:0] SYM_ZERO  = 6'd48;

  // One classified byte: nsym symbols, then an implied closing star.
  typedef struct packed {
    logic [2:0]                  nsym;
    logic [SlotN-1:0][SymW-1:0]  sym;
  } mte_run_t;

  // Keypad digit of letter index 0..25 (a..z).
  function automatic logic [3:0] key_digit(input logic [4:0] idx);
    logic [3:0] d;
    case (idx) inside
      [5'd0:5'd2]:   d = 4'd2;
      [5'd3:5'd5]:   d = 4'd3;
      [5'd6:5'd8]:   d = 4'd4;
      [5'd9:5'd11]:  d = 4'd5;
      [5'd12:5'd14]: d = 4'd6;
      [5'd15:5'd18]: d = 4'd7;
      [5'd19:5'd21]: d = 4'd8;
      default:       d = 4'd9;
    endcase
    return d;
  endfunction

  // Presses needed for letter index 0..25.
  function automatic logic [2:0] key_taps(input logic [4:0] idx);
    logic [2:0] t;
    case (idx) inside
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd19, 5'd22:  t = 3'd1;
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd20, 5'd23: t = 3'd2;
      5'd18, 5'd25:                                         t = 3'd4;
      default:                                              t = 3'd3;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/mte_front.sv
// Front end: classifies one input byte into a run descriptor.
// Depends on mte_pkg.
module mte_front (
  input  logic [7:0]        in_byte,
  output mte_pkg::mte_run_t run
);

  logic       is_space;
  logic       is_upper;
  logic       is_lower;
  logic [4:0] idx;
  logic [3:0] digit;
  logic [2:0] taps;
  logic [2:0] off;
  logic       neg;
  logic [7:0] mag;
  logic       has_hund;
  logic [6:0] rem;
  logic [14:0] prod;
  logic [3:0] tens;
  logic [6:0] tens_x10;
  logic [3:0] ones;
  logic [2:0] pos;

  assign is_space = (in_byte == 8'd32);
  assign is_upper = (in_byte >= 8'd65) && (in_byte <= 8'd90);
  assign is_lower = (in_byte >= 8'd97) && (in_byte <= 8'd122);
  assign idx      = is_upper ? 5'(in_byte - 8'd65) : 5'(in_byte - 8'd97);
  assign digit    = mte_pkg::key_digit(idx);
  assign taps     = mte_pkg::key_taps(idx);
  assign off      = is_upper ? 3'd1 : 3'd0;

  // Signed reading of the byte; magnitude never exceeds 128.
  assign neg      = in_byte[7];
  assign mag      = neg ? 8'(8'd0 - in_byte) : in_byte;
  assign has_hund = (mag >= 8'd100);
  assign rem      = has_hund ? 7'(mag - 8'd100) : mag[6:0];
  // Divide by ten through the reciprocal 205/2048, exact below 1029.
  assign prod     = 15'(rem) * 15'd205;
  assign tens     = prod[14:11];
  assign tens_x10 = 7'(tens) * 7'd10;
  assign ones     = 4'(rem - tens_x10);

  always_comb begin
    run.sym  = '0;
    run.nsym = 3'd0;
    pos      = 3'd0;
    if (is_space) begin
      run.sym[0] = mte_pkg::SYM_ZERO;
      run.nsym   = 3'd1;
    end else if (is_upper || is_lower) begin
      if (is_upper) begin
        run.sym[0] = mte_pkg::SYM_MINUS;
      end
      for (int p = 0; p < mte_pkg::SlotN; p++) begin
        if ((3'(p) >= off) && (3'(p) < 3'(off + taps))) begin
          run.sym[p] = mte_pkg::SYM_ZERO + 6'(digit);
        end
      end
      run.nsym = 3'(off + taps);
    end else begin
      if (neg) begin
        run.sym[pos] = mte_pkg::SYM_MINUS;
        pos          = pos + 3'd1;
      end
      if (has_hund) begin
        run.sym[pos] = mte_pkg::SYM_ZERO + 6'd1;
        pos          = pos + 3'd1;
      end
      if (has_hund || (mag >= 8'd10)) begin
        run.sym[pos] = mte_pkg::SYM_ZERO + 6'(tens);
        pos          = pos + 3'd1;
      end
      run.sym[pos] = mte_pkg::SYM_ZERO + 6'(ones);
      run.nsym     = pos + 3'd1;
    end
  end

endmodule

FILE: rtl/core/mte_queue.sv
// Short queue of run descriptors between front and back ends.
// Depends on mte_pkg.
module mte_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mte_pkg::mte_run_t push_run,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output mte_pkg::mte_run_t head_run
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mte_pkg::mte_run_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_run   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

FILE: rtl/core/mte_back.sv
// Back end: walks the head descriptor and drives one symbol per beat.
// Depends on mte_pkg.
module mte_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  mte_pkg::mte_run_t head_run,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        out_symbol,
  output logic              out_last
);

  logic       out_valid_r, out_valid_nxt;
  logic [5:0] out_symbol_r, out_symbol_nxt;
  logic       out_last_r, out_last_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       load;
  logic       at_star;

  // Output register is free when empty or being taken this cycle.
  assign load    = !out_valid_r || out_ready;
  assign at_star = (pos_r == head_run.nsym);
  assign pop     = head_valid && load && at_star;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    pos_nxt        = pos_r;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        out_last_nxt = at_star;
        if (at_star) begin
          out_symbol_nxt = mte_pkg::SYM_STAR;
          pos_nxt        = 3'd0;
        end else begin
          out_symbol_nxt = head_run.sym[pos_r];
          pos_nxt        = pos_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

FILE: rtl/core/multitap_text_encoder_top.sv
// Multitap text encoder: each byte becomes a run of 2 to 6 symbols ending in '*'.
// The first symbol of a byte passes through the descriptor queue and the back-end output register.
// Throughput: one symbol per cycle from the back end while out_ready stays high.
// The descriptor queue (QUEUE_DEPTH runs) lets input beats arrive while output stalls.
// Reset (rst_n low, synchronous) empties the queue and drops any pending symbol.
module multitap_text_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_symbol,
  output logic       out_last
);

  mte_pkg::mte_run_t front_run;
  mte_pkg::mte_run_t head_run;
  logic              q_full;
  logic              head_valid;
  logic              pop;
  logic              push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  mte_front u_front (
    .in_byte (in_byte),
    .run     (front_run)
  );

  mte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_run   (front_run),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_run   (head_run)
  );

  mte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_run   (head_run),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

endmodule

FILE: rtl/core/mte_checker.sv
// Port-level checks for the multitap text encoder, bound to the top level.
// Depends on mte_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mte_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_symbol,
  input logic       out_last
);

  logic is_star;
  logic is_minus;
  logic body_ok;
  logic minus_beat;

  assign is_star    = (out_symbol == mte_pkg::SYM_STAR);
  assign is_minus   = (out_symbol == mte_pkg::SYM_MINUS);
  // Body beats are a minus or a decimal digit, never a star.
  assign body_ok    = is_minus ||
                      ((out_symbol >= mte_pkg::SYM_ZERO) && (out_symbol <= 6'd57));
  assign minus_beat = out_valid && out_ready && is_minus;

  `MTE_ASSERT(a_last_is_star, out_valid && out_last |-> is_star, "closing beat is not a star")
  `MTE_ASSERT(a_body_not_star, out_valid && !out_last |-> body_ok, "body beat not minus or digit")
  `MTE_ASSERT(a_minus_leads, minus_beat |=> out_valid && !is_minus && !out_last, "minus alone")
  `MTE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind multitap_text_encoder_top mte_checker u_mte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_symbol (out_symbol),
  .out_last   (out_last)
);

FILE: verif/tb_multitap_text_encoder_top.sv
// Testbench for multitap_text_encoder_top: drives text bytes and checks every output symbol
// against a behavioral keypad-run predictor. Depends on mte_pkg and the top module only.
module tb_multitap_text_encoder_top;

  localparam int IdleLimit = 1000;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;

  typedef struct packed {
    logic [mte_pkg::SymW-1:0] symbol;
    logic                     last;
  } symbol_beat_t;

  typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_BLIP, RX_CHOKE} rx_mode_e;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      in_byte = 8'd0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [5:0]      out_symbol;
  logic            out_last;

  logic [3:0] keypad_digit [0:25] = '{2, 2, 2, 3, 3, 3, 4, 4, 4, 5, 5, 5, 6,
                                      6, 6, 7, 7, 7, 7, 8, 8, 8, 9, 9, 9, 9};
  logic [2:0] keypad_taps  [0:25] = '{1, 2, 3, 1, 2, 3, 1, 2, 3, 1, 2, 3, 1,
                                      2, 3, 1, 2, 3, 4, 1, 2, 3, 1, 2, 3, 4};

  symbol_beat_t expected_symbols [$];
  int           error_count = 0;
  int           idle_cycles = 0;
  bit           sender_gaps_on = 1'b1;
  int           burst_left = 4;
  rx_mode_e     rx_mode = RX_FLOW;
  int           rx_phase = 0;

  multitap_text_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_symbol(out_symbol),
    .out_last  (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void push_symbol(input logic [mte_pkg::SymW-1:0] sym, input logic last);
    symbol_beat_t beat;
    beat.symbol = sym;
    beat.last = last;
    expected_symbols.push_back(beat);
  endfunction

  function automatic logic [mte_pkg::SymW-1:0] digit_symbol(input int d);
    return mte_pkg::SymW'(mte_pkg::SYM_ZERO + d);
  endfunction

  // Expand one byte into its keypad run and queue the symbols.
  function automatic void predict_keypad_run(input logic [7:0] b);
    int  idx;
    int  mag;
    bit  upper;
    upper = (b >= CH_UPPER_A && b <= CH_UPPER_Z);
    if (b == CH_SPACE) begin
      push_symbol(mte_pkg::SYM_ZERO, 1'b0);
    end else if (upper || (b >= CH_LOWER_A && b <= CH_LOWER_Z)) begin
      if (upper) begin
        push_symbol(mte_pkg::SYM_MINUS, 1'b0);
        idx = b - CH_UPPER_A;
      end else begin
        idx = b - CH_LOWER_A;
      end
      for (int t = 0; t < keypad_taps[idx]; t++)
        push_symbol(digit_symbol(keypad_digit[idx]), 1'b0);
    end else begin
      mag = b;
      // read as signed char
      if (b[7]) begin
        push_symbol(mte_pkg::SYM_MINUS, 1'b0);
        mag = 256 - b;
      end
      if (mag >= 100) push_symbol(digit_symbol(mag / 100), 1'b0);
      if (mag >= 10) push_symbol(digit_symbol((mag / 10) % 10), 1'b0);
      push_symbol(digit_symbol(mag % 10), 1'b0);
    end
    push_symbol(mte_pkg::SYM_STAR, 1'b1);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Predict on input beats, compare on output beats, watch for a hang.
  always @(posedge clk) begin
    symbol_beat_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_keypad_run(in_byte);
      if (out_valid && out_ready) begin
        if (expected_symbols.size() == 0) begin
          report_mismatch("unexpected symbol", out_symbol, -1);
        end else begin
          want = expected_symbols.pop_front();
          if (out_symbol !== want.symbol) report_mismatch("symbol", out_symbol, want.symbol);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // Receiver stalls follow a randomly chosen mode that is redrawn when rx_phase runs out.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_phase = $urandom_range(20, 80);
      end
      rx_phase--;
      case (rx_mode)
        RX_FLOW:  out_ready <= 1'b1;
        RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
        RX_BLIP:  out_ready <= (rx_phase % 6) != 0;
        default:  out_ready <= (rx_phase % 10) < 3;
      endcase
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat, or later when a sender gap follows.
  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (sender_gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  // Hold the sender until every queued symbol has come out.
  task automatic drain_symbols();
    in_valid <= 1'b0;
    while (expected_symbols.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic test_directed_bytes();
    logic [7:0] picks [0:24] = '{8'd0, 8'd32, 8'd97, 8'd99, 8'd115, 8'd122, 8'd65, 8'd83,
                                 8'd90, 8'd87, 8'd10, 8'd9, 8'd99, 8'd100, 8'd127, 8'd128,
                                 8'd255, 8'd129, 8'd156, 8'd246, 8'd57, 8'd64, 8'd91,
                                 8'd96, 8'd123};
    foreach (picks[i]) send_byte(picks[i]);
    drain_symbols();
  endtask

  // Text-like bytes back to back, no sender gaps.
  task automatic test_letter_runs();
    int         pick;
    logic [7:0] b;
    sender_gaps_on = 1'b0;
    repeat (60) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) b = CH_SPACE;
      else if (pick < 5) b = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
      else b = 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
      send_byte(b);
    end
    drain_symbols();
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_random_bytes();
    repeat (100) send_byte(8'($urandom_range(0, 255)));
    drain_symbols();
  endtask

  task automatic test_paced_bytes();
    repeat (5) begin
      repeat (8) send_byte(8'($urandom_range(0, 255)));
      drain_symbols();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_bytes();
    test_letter_runs();
    test_random_bytes();
    test_paced_bytes();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: multitap_text_encoder_top.f
+incdir+rtl/core
rtl/core/mte_pkg.sv
rtl/core/mte_front.sv
rtl/core/mte_queue.sv
rtl/core/mte_back.sv
rtl/core/multitap_text_encoder_top.sv
rtl/core/mte_checker.sv
verif/tb_multitap_text_encoder_top.sv
